FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int QueueDepth = 16;
  localparam int PrioBits   = 16;

  localparam int PrioW = (PrioBits < 16) ? PrioBits : 16;
  localparam int CntW  = $clog2(QueueDepth + 1);

  localparam logic [1:0] ModeInsert = 2'd0;
  localparam logic [1:0] ModePoll   = 2'd1;
  localparam logic [1:0] ModePeek   = 2'd2;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  typedef struct packed {
    logic signed [31:0] value;
    logic [PrioW-1:0]   prio;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   poll;
    entry_t fresh;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  wire logic               clk_i,
  input  wire spq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic               occupied_i,
  input  wire spq_pkg::entry_t    left_i,
  input  wire logic               left_le_i,
  input  wire spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t         entry_o,
  output logic                    le_o
);

  spq_pkg::entry_t entry_q;
  spq_pkg::entry_t entry_d;

  // The cell stays put when it is occupied and not later than the new request.
  assign le_o = occupied_i && (entry_q.prio <= ctrl_i.fresh.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (!le_o) begin
        entry_d = left_le_i ? ctrl_i.fresh : left_i;
      end
    end else if (ctrl_i.poll) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

FILE: rtl/stable_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted priority queue built as a row of cells, one per slot, head in cell zero.
// Every request (insert, poll or peek) is applied at once: all cells
// compare their priority against the request in parallel and each loads from
// itself, its neighbor or the new entry, so a new request is taken every cycle
// while the result register is free or being drained. Equal priorities leave in
// arrival order. A full insert is dropped and reported; poll or peek on an empty
// queue is reported as empty.
module stable_priority_queue_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic [15:0]        priority_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [31:0]      head_value_o,
  output logic [15:0]             head_priority_o,
  output logic [4:0]              occupancy_o
);

  localparam int Depth = spq_pkg::QueueDepth;
  localparam int CntW  = spq_pkg::CntW;
  localparam int PrioW = spq_pkg::PrioW;

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [1:0]      status_q, status_d;
  logic signed [31:0] head_value_q, head_value_d;
  logic [15:0]     head_prio_q, head_prio_d;
  logic [4:0]      occ_q;

  logic in_fire, full, empty, do_insert, do_poll;
  logic [CntW+4:0] count_wide;
  logic [PrioW+15:0] prio_wide;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     entries [Depth];
  logic [Depth-1:0]    le;
  logic [Depth-1:0]    occupied;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(Depth));
  assign empty      = (count_q == '0);
  assign do_insert  = in_fire && (mode_i == spq_pkg::ModeInsert) && !full;
  assign do_poll    = in_fire && (mode_i == spq_pkg::ModePoll) && !empty;

  assign ctrl.insert      = do_insert;
  assign ctrl.poll        = do_poll;
  assign ctrl.fresh.value = item_value_i;
  assign ctrl.fresh.prio  = priority_req_i[PrioW-1:0];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::entry_t left_e, right_e;
    logic            left_le;

    assign occupied[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_e  = ctrl.fresh;
      assign left_le = 1'b1;
    end else begin : g_mid
      assign left_e  = entries[i-1];
      assign left_le = le[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_body
      assign right_e = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (occupied[i]),
      .left_i     (left_e),
      .left_le_i  (left_le),
      .right_i    (right_e),
      .entry_o    (entries[i]),
      .le_o       (le[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    status_d     = spq_pkg::StatusOk;
    head_value_d = '0;
    head_prio_d  = '0;
    prio_wide    = {16'd0, entries[0].prio};
    case (mode_i)
      spq_pkg::ModeInsert: begin
        if (full) begin
          status_d = spq_pkg::StatusFull;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      spq_pkg::ModePoll, spq_pkg::ModePeek: begin
        if (empty) begin
          status_d = spq_pkg::StatusEmpty;
        end else begin
          head_value_d = entries[0].value;
          head_prio_d  = prio_wide[15:0];
          if (mode_i == spq_pkg::ModePoll) begin
            count_d = count_q - CntW'(1);
          end
        end
      end
      default: begin
        status_d = spq_pkg::StatusOk;
      end
    endcase
  end

  assign count_wide = {5'd0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q     <= status_d;
      head_value_q <= head_value_d;
      head_prio_q  <= head_prio_d;
      occ_q        <= count_wide[4:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign head_value_o    = head_value_q;
  assign head_priority_o = head_prio_q;
  assign occupancy_o     = occ_q;

  // The fill count never passes the number of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count exceeds depth");

  // A dropped insert leaves the queue full and reports it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (mode_i == spq_pkg::ModeInsert) && full
    |=> (count_q == CntW'(Depth)) && (status_q == spq_pkg::StatusFull))
    else $error("full insert not dropped");

  // A poll of a non-empty queue removes exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (mode_i == spq_pkg::ModePoll) && !empty
    |=> count_q == $past(count_q) - CntW'(1))
    else $error("poll count mismatch");

  // A peek never changes the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (mode_i == spq_pkg::ModePeek) |=> $stable(count_q))
    else $error("peek changed count");

  // The cells that stay put on an insert form a prefix of the occupied cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((le & ~occupied) == '0) && (((le >> 1) & ~le) == '0))
    else $error("cell order broken");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int RandomOps = 2000;

  typedef struct {
    logic [1:0]         mode;
    logic signed [31:0] value;
    logic [15:0]        prio;
    bit                 drain_first;
  } queue_op_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [15:0]        prio;
    logic [4:0]         occupancy;
  } head_report_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [1:0]         mode = spq_pkg::ModeInsert;
  logic signed [31:0] item_value = '0;
  logic [15:0]        priority_req = '0;
  logic               out_stall = 1'b0;
  wire                in_stall;
  wire                out_valid;
  wire [1:0]          status;
  wire signed [31:0]  head_value;
  wire [15:0]         head_priority;
  wire [4:0]          occupancy;

  queue_op_t       op_backlog[$];
  head_report_t    due_results[$];
  spq_pkg::entry_t shadow_entries[$];
  int              mismatches = 0;
  int              requests_taken = 0;
  int              burst_left = 8;
  int              gap_left = 0;
  int              hold_left = 0;
  bit              long_hold_done = 1'b0;
  logic [31:0]     stall_cycle = '0;

  stable_priority_queue_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .item_value_i   (item_value),
    .priority_req_i (priority_req),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .head_value_o   (head_value),
    .head_priority_o(head_priority),
    .occupancy_o    (occupancy)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic head_report_t apply_queue_op(queue_op_t op);
    head_report_t    r;
    spq_pkg::entry_t fresh;
    int              pos;
    r.status = spq_pkg::StatusOk;
    r.value = '0;
    r.prio = '0;
    if (op.mode == spq_pkg::ModeInsert) begin
      if (shadow_entries.size() >= spq_pkg::QueueDepth) begin
        r.status = spq_pkg::StatusFull;
      end else begin
        fresh.value = op.value;
        fresh.prio = op.prio[spq_pkg::PrioW-1:0];
        pos = 0;
        while (pos < shadow_entries.size() && shadow_entries[pos].prio <= fresh.prio) pos++;
        shadow_entries.insert(pos, fresh);
      end
    end else if (op.mode == spq_pkg::ModePoll || op.mode == spq_pkg::ModePeek) begin
      if (shadow_entries.size() == 0) begin
        r.status = spq_pkg::StatusEmpty;
      end else begin
        r.value = shadow_entries[0].value;
        r.prio = 16'(shadow_entries[0].prio);
        if (op.mode == spq_pkg::ModePoll) shadow_entries.pop_front();
      end
    end
    r.occupancy = 5'(shadow_entries.size());
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 40) begin
      $display("%0t mismatch in %s: got %h, expected %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic add_op(logic [1:0] m, logic [31:0] v, logic [15:0] p, bit drain = 1'b0);
    queue_op_t op;
    op.mode = m;
    op.value = v;
    op.prio = p;
    op.drain_first = drain;
    op_backlog.push_back(op);
  endtask

  always @(posedge clk or negedge rst_n) begin : sender
    queue_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        op.mode = mode;
        op.value = item_value;
        op.prio = priority_req;
        due_results.push_back(apply_queue_op(op));
        requests_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_backlog.size() != 0 &&
                     (!op_backlog[0].drain_first || due_results.size() == 0)) begin
          op = op_backlog.pop_front();
          in_valid <= 1'b1;
          mode <= op.mode;
          item_value <= op.value;
          priority_req <= op.prio;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(40, 120);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 24);
              gap_left = $urandom_range(1, 6);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (!long_hold_done && requests_taken >= 600) begin
        hold_left = 300;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_cycle[8:7])
          2'd0: out_stall <= 1'b0;
          2'd1: out_stall <= ($urandom_range(0, 1) == 0);
          2'd2: out_stall <= ($urandom_range(0, 9) == 0);
          default: out_stall <= (stall_cycle % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    head_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_mismatch("unrequested result status", 32'(status), 32'(spq_pkg::StatusOk));
      end else begin
        want = due_results.pop_front();
        if (status !== want.status) flag_mismatch("status", 32'(status), 32'(want.status));
        if (head_value !== want.value) flag_mismatch("head_value", head_value, want.value);
        if (head_priority !== want.prio) begin
          flag_mismatch("head_priority", 32'(head_priority), 32'(want.prio));
        end
        if (occupancy !== want.occupancy) begin
          flag_mismatch("occupancy", 32'(occupancy), 32'(want.occupancy));
        end
      end
    end
  end

  initial begin : stimulus
    int          issued;
    int          seg_len;
    int          seg_kind;
    int          prio_kind;
    int          pick;
    logic [1:0]  m;
    logic [15:0] p;
    bit          drain_done;

    add_op(spq_pkg::ModePoll, 32'h1234_5678, 16'h00ff);
    add_op(spq_pkg::ModePeek, 32'h8765_4321, 16'hff00);
    add_op(ModeUnused, 32'hdead_beef, 16'hbeef);
    add_op(spq_pkg::ModeInsert, 32'h7fff_ffff, 16'hffff);
    add_op(spq_pkg::ModeInsert, 32'h8000_0000, 16'h0000);
    add_op(spq_pkg::ModeInsert, 32'hffff_ffff, 16'h0000);
    add_op(spq_pkg::ModeInsert, 32'h0000_0000, 16'h8000);
    add_op(spq_pkg::ModeInsert, 32'h0000_0001, 16'h8000);
    add_op(spq_pkg::ModeInsert, 32'h5555_5555, 16'h5555);
    add_op(spq_pkg::ModeInsert, 32'haaaa_aaaa, 16'haaaa);
    add_op(spq_pkg::ModeInsert, 32'h0000_0002, 16'h0000);
    add_op(spq_pkg::ModeInsert, 32'h0000_0003, 16'hffff);
    add_op(spq_pkg::ModeInsert, 32'h0000_0004, 16'h0001);
    add_op(spq_pkg::ModeInsert, 32'h0000_0005, 16'h7fff);
    add_op(spq_pkg::ModeInsert, 32'h0000_0006, 16'h0001);
    add_op(spq_pkg::ModeInsert, 32'h0000_0007, 16'hfffe);
    add_op(spq_pkg::ModeInsert, 32'h0000_0008, 16'h8000);
    add_op(spq_pkg::ModeInsert, 32'h0000_0009, 16'h0100);
    add_op(spq_pkg::ModeInsert, 32'h0000_000a, 16'h0000);
    add_op(spq_pkg::ModeInsert, 32'h0000_000b, 16'h0000);
    add_op(ModeUnused, 32'h0f0f_0f0f, 16'hf0f0);
    add_op(spq_pkg::ModePeek, 32'h0, 16'h0);
    add_op(spq_pkg::ModePoll, 32'h0, 16'h0);
    add_op(spq_pkg::ModePoll, 32'h0, 16'h0);
    add_op(spq_pkg::ModeInsert, 32'h1234_5678, 16'h0000);

    issued = 0;
    drain_done = 1'b0;
    while (issued < RandomOps) begin
      seg_len = $urandom_range(20, 80);
      seg_kind = $urandom_range(0, 3);
      prio_kind = $urandom_range(0, 3);
      repeat (seg_len) begin
        pick = $urandom_range(0, 99);
        case (seg_kind)
          0: m = (pick < 70) ? spq_pkg::ModeInsert : (pick < 90) ? spq_pkg::ModePoll :
                 (pick < 98) ? spq_pkg::ModePeek : ModeUnused;
          1: m = (pick < 25) ? spq_pkg::ModeInsert : (pick < 85) ? spq_pkg::ModePoll :
                 (pick < 98) ? spq_pkg::ModePeek : ModeUnused;
          2: m = (pick < 45) ? spq_pkg::ModeInsert : (pick < 85) ? spq_pkg::ModePoll :
                 (pick < 98) ? spq_pkg::ModePeek : ModeUnused;
          default: m = 2'($urandom_range(0, 3));
        endcase
        case (prio_kind)
          0: p = 16'($urandom_range(0, 3));
          1: p = 16'($urandom_range(65532, 65535));
          2: p = 16'($urandom);
          default: p = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        endcase
        add_op(m, $urandom, p, !drain_done && issued >= 1300);
        if (issued >= 1300) drain_done = 1'b1;
        issued++;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (op_backlog.size() != 0 || in_valid || due_results.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
